@@ hdl/swlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Stopwatch lap timer package
// Shared widths, operation and run state codes, the log RAM request type and
// the saturating helpers.
// ----------------------------------------------------------------------------
package swlt_pkg;

   localparam int LOG_DEPTH = 16;
   localparam int SLOT_W    = $clog2(LOG_DEPTH);
   localparam int CNT_W     = 32;
   localparam int LIM_W     = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // operation codes
   localparam logic [2:0] FN_TICK       = 3'd0;
   localparam logic [2:0] FN_START      = 3'd1;
   localparam logic [2:0] FN_STOP       = 3'd2;
   localparam logic [2:0] FN_LAP        = 3'd3;
   localparam logic [2:0] FN_CLEAR      = 3'd4;
   localparam logic [2:0] FN_READ_TOTAL = 3'd5;
   localparam logic [2:0] FN_READ_LOG   = 3'd6;
   localparam logic [2:0] FN_READ_STATE = 3'd7;

   // run state codes
   localparam logic [1:0] RS_IDLE    = 2'd0;
   localparam logic [1:0] RS_RUNNING = 2'd1;
   localparam logic [1:0] RS_STOPPED = 2'd2;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      logic [CNT_W-1:0]  wdata;
      logic              re;
      logic [SLOT_W-1:0] raddr;
   } mem_req_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   // clamp the configured ring size to 1..LOG_DEPTH
   function automatic logic [LIM_W-1:0] log_limit(input logic [LIM_W-1:0] m);
      logic [LIM_W-1:0] r;
      if (m == '0) begin
         r = LIM_W'(1);
      end else if (m > LIM_W'(LOG_DEPTH)) begin
         r = LIM_W'(LOG_DEPTH);
      end else begin
         r = m;
      end
      return r;
   endfunction

endpackage

@@ hdl/stopwatch_lap_timer_top.sv @@
// ----------------------------------------------------------------------------
// Stopwatch lap timer
// Tick-driven stopwatch with a ring log of lap lengths held in a RAM.
// ----------------------------------------------------------------------------
// Each transaction gives exactly one response, marked by rsp_strobe for one
// cycle, and the receiver cannot stall it. Tick, start, clear, read_total,
// read_state and every refused command are accepted back to back: the
// response comes the cycle after acceptance and busy stays low. read_log
// reads the log RAM, whose read data is registered; busy holds in the
// read state and the response is registered after it. stop and lap respond
// the next cycle, but busy holds while the newest log entry is read,
// updated and written back through the single RAM write port, and for lap
// while the next ring slot is zeroed. csr_max_log_num is taken only while
// busy is low.
// ----------------------------------------------------------------------------
module stopwatch_lap_timer_top
   import swlt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_func,
   input  logic [3:0]        req_log_index,
   output logic              rsp_strobe,
   output logic              rsp_ok,
   output logic [CNT_W-1:0]  rsp_value,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LIM_W-1:0]  csr_max_log_num
);

   logic [LIM_W-1:0] max_log_ff;
   mem_req_type      mem_req;
   logic [CNT_W-1:0] rd_data;
   logic             ctrl_busy;

   assign csr_ready = !ctrl_busy;
   assign busy      = ctrl_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_log_ff <= LIM_W'(LOG_DEPTH);
      end else if (csr_valid && csr_ready) begin
         max_log_ff <= csr_max_log_num;
      end
   end

   swlt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (ctrl_busy),
      .req_func      (req_func),
      .req_log_index (req_log_index),
      .max_log_num   (max_log_ff),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_ok        (rsp_ok),
      .rsp_value     (rsp_value)
   );

   swlt_lap_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

@@ hdl/swlt_lap_ram.sv @@
// ----------------------------------------------------------------------------
// Lap log RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swlt_lap_ram
   import swlt_pkg::*;
(
   input  logic             clock,
   input  mem_req_type      mem_req,
   output logic [CNT_W-1:0] rd_data
);

   logic [CNT_W-1:0] mem_ff [LOG_DEPTH];
   logic [CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/swlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stopwatch lap timer controller
// Decodes commands, keeps run state and counters, and sequences the
// read-modify-write of the newest log entry and the ring push.
// ----------------------------------------------------------------------------
module swlt_ctrl
   import swlt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_func,
   input  logic [3:0]        req_log_index,
   input  logic [LIM_W-1:0]  max_log_num,
   output mem_req_type       mem_req,
   input  logic [CNT_W-1:0]  rd_data,
   output logic              rsp_strobe,
   output logic              rsp_ok,
   output logic [CNT_W-1:0]  rsp_value
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FOLD  = 2'd1;
   localparam logic [1:0] ST_PUSH  = 2'd2;
   localparam logic [1:0] ST_RDLOG = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        run_ff, run_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  seg_ff, seg_in;
   logic [CNT_W-1:0]  fold_ff, fold_in;
   logic              lap_ff, lap_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [LIM_W-1:0]  count_ff, count_in;
   logic              strobe_ff, strobe_in;
   logic              ok_ff, ok_in;
   logic [CNT_W-1:0]  value_ff, value_in;

   logic              accept;
   logic [LIM_W-1:0]  lim;
   logic [LIM_W:0]    count_p1;
   logic [LIM_W-1:0]  count_next;
   logic [SLOT_W-1:0] push_slot;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign lim        = log_limit(max_log_num);
   assign count_p1   = {1'b0, count_ff} + (LIM_W+1)'(1);
   assign count_next = (count_p1 > {1'b0, lim}) ? lim : count_p1[LIM_W-1:0];
   assign push_slot  = newest_ff + SLOT_W'(1);

   always_comb begin
      state_in  = state_ff;
      run_in    = run_ff;
      total_in  = total_ff;
      seg_in    = seg_ff;
      fold_in   = fold_ff;
      lap_in    = lap_ff;
      newest_in = newest_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      ok_in     = ok_ff;
      value_in  = value_ff;
      mem_req   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               ok_in     = 1'b1;
               value_in  = '0;
               case (req_func)
                  FN_TICK: begin
                     if (run_ff == RS_RUNNING) begin
                        seg_in = sat_add(seg_ff, CNT_W'(1));
                     end
                  end
                  FN_START: begin
                     if (run_ff == RS_IDLE) begin
                        // open a fresh log entry of zero
                        total_in      = '0;
                        newest_in     = push_slot;
                        count_in      = count_next;
                        mem_req.we    = 1'b1;
                        mem_req.waddr = push_slot;
                        mem_req.wdata = '0;
                        seg_in        = '0;
                        run_in        = RS_RUNNING;
                     end else if (run_ff == RS_STOPPED) begin
                        seg_in = '0;
                        run_in = RS_RUNNING;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  FN_STOP, FN_LAP: begin
                     if (run_ff == RS_RUNNING) begin
                        // fetch newest entry; fold the segment next cycle
                        if (req_func == FN_LAP) begin
                           value_in = seg_ff;
                        end else begin
                           run_in = RS_STOPPED;
                        end
                        total_in      = sat_add(total_ff, seg_ff);
                        fold_in       = seg_ff;
                        lap_in        = (req_func == FN_LAP);
                        seg_in        = '0;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = newest_ff;
                        state_in      = ST_FOLD;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  FN_CLEAR: begin
                     total_in = '0;
                     seg_in   = '0;
                     count_in = '0;
                     run_in   = RS_IDLE;
                  end
                  FN_READ_TOTAL: begin
                     if (run_ff == RS_RUNNING) begin
                        value_in = sat_add(total_ff, seg_ff);
                     end else if (run_ff == RS_STOPPED) begin
                        value_in = total_ff;
                     end
                  end
                  FN_READ_LOG: begin
                     if ({1'b0, req_log_index} < count_ff) begin
                        strobe_in     = 1'b0;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = newest_ff - SLOT_W'(req_log_index);
                        state_in      = ST_RDLOG;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  FN_READ_STATE: begin
                     value_in = CNT_W'(run_ff);
                  end
                  default: begin
                     value_in = '0;
                  end
               endcase
            end
         end
         ST_FOLD: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = newest_ff;
            mem_req.wdata = sat_add(rd_data, fold_ff);
            state_in      = lap_ff ? ST_PUSH : ST_IDLE;
         end
         ST_PUSH: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = push_slot;
            mem_req.wdata = '0;
            newest_in     = push_slot;
            count_in      = count_next;
            state_in      = ST_IDLE;
         end
         ST_RDLOG: begin
            strobe_in = 1'b1;
            ok_in     = 1'b1;
            value_in  = rd_data;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         run_ff    <= RS_IDLE;
         total_ff  <= '0;
         seg_ff    <= '0;
         lap_ff    <= 1'b0;
         newest_ff <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         run_ff    <= run_in;
         total_ff  <= total_in;
         seg_ff    <= seg_in;
         lap_ff    <= lap_in;
         newest_ff <= newest_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff  <= fold_in;
      ok_ff    <= ok_in;
      value_ff <= value_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_ok     = ok_ff;
   assign rsp_value  = value_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LIM_W'(LOG_DEPTH))
      else $error("entry count exceeds log depth");

   a_fold_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> $past(accept))
      else $error("fold entered without an accepted stop or lap");

   a_push_after_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> ($past(state_ff) == ST_FOLD) && $past(lap_ff))
      else $error("push not preceded by a lap fold");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(accept) || ($past(state_ff) == ST_RDLOG)))
      else $error("response without a transaction behind it");
`endif

endmodule

@@ verif/tb_stopwatch_lap_timer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stopwatch lap timer testbench
// Drives tick, start, stop, lap, clear and read commands through the start and
// busy handshake, first from a short directed table and then in random phases
// at several ring sizes. A command-level predictor of the stopwatch state works
// out each response the table does not give, and every strobed response is checked in order.
// ----------------------------------------------------------------------------
module tb_stopwatch_lap_timer_top;
   import swlt_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TIME  = 4;
   localparam int PHASE_ITEMS  = 93;
   localparam int NUM_PHASES   = 7;
   localparam int NUM_DIRECTED = 25;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] value;
   } sw_resp_type;

   // typed = 1: the response is written in the row, else it is predicted
   typedef struct packed {
      logic [2:0]       func;
      logic [3:0]       idx;
      logic             typed;
      logic             ok;
      logic [CNT_W-1:0] value;
   } cmd_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [2:0]       req_func;
   logic [3:0]       req_log_index;
   logic             rsp_strobe;
   logic             rsp_ok;
   logic [CNT_W-1:0] rsp_value;
   logic             csr_valid;
   logic             csr_ready;
   logic [LIM_W-1:0] csr_max_log_num;

   // stopwatch state as the testbench sees it
   logic [LIM_W-1:0]  ring_cfg;
   logic [1:0]        run_mode;
   logic [CNT_W-1:0]  total_cnt;
   logic [CNT_W-1:0]  seg_cnt;
   logic [CNT_W-1:0]  lap_log [LOG_DEPTH];
   logic [SLOT_W-1:0] head_slot;
   logic [LIM_W-1:0]  lap_count;

   sw_resp_type pending_resps[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          no_gaps = 1'b0;

   cmd_row_type dir_rows [NUM_DIRECTED] = '{
      '{FN_READ_STATE, 4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_READ_TOTAL, 4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_READ_LOG,   4'd0,  1'b1, 1'b0, 32'd0},
      '{FN_READ_LOG,   4'd15, 1'b1, 1'b0, 32'd0},
      '{FN_STOP,       4'd0,  1'b1, 1'b0, 32'd0},
      '{FN_LAP,        4'd0,  1'b1, 1'b0, 32'd0},
      '{FN_TICK,       4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_START,      4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_START,      4'd0,  1'b1, 1'b0, 32'd0},
      '{FN_TICK,       4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_TICK,       4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_TICK,       4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_LAP,        4'd0,  1'b1, 1'b1, 32'd3},
      '{FN_TICK,       4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_READ_TOTAL, 4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_READ_LOG,   4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_READ_LOG,   4'd1,  1'b1, 1'b1, 32'd3},
      '{FN_STOP,       4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_READ_STATE, 4'd0,  1'b1, 1'b1, 32'd2},
      '{FN_READ_LOG,   4'd0,  1'b0, 1'b0, 32'd0},
      '{FN_START,      4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_READ_STATE, 4'd0,  1'b1, 1'b1, 32'd1},
      '{FN_READ_LOG,   4'd2,  1'b1, 1'b0, 32'd0},
      '{FN_CLEAR,      4'd0,  1'b1, 1'b1, 32'd0},
      '{FN_READ_STATE, 4'd0,  1'b1, 1'b1, 32'd0}
   };

   always #CLK_HALF clock = ~clock;

   stopwatch_lap_timer_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_log_index   (req_log_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_value       (rsp_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_log_num (csr_max_log_num)
   );

   function automatic logic [CNT_W-1:0] add_clip(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

   function automatic logic [LIM_W-1:0] ring_limit();
      if (ring_cfg == '0) begin
         return LIM_W'(1);
      end
      if (ring_cfg > LIM_W'(LOG_DEPTH)) begin
         return LIM_W'(LOG_DEPTH);
      end
      return ring_cfg;
   endfunction

   // advance the ring head, zero the new entry, trim any surplus to the limit
   function automatic void open_entry();
      head_slot = head_slot + 1'b1;
      lap_log[head_slot] = '0;
      if (lap_count < ring_limit()) begin
         lap_count = lap_count + 1'b1;
      end else begin
         lap_count = ring_limit();
      end
   endfunction

   function automatic void fold_segment();
      total_cnt = add_clip(total_cnt, seg_cnt);
      lap_log[head_slot] = add_clip(lap_log[head_slot], seg_cnt);
   endfunction

   function automatic sw_resp_type apply_command(input logic [2:0] func,
                                                 input logic [3:0] idx);
      sw_resp_type       r;
      logic [SLOT_W-1:0] slot;
      r.ok = 1'b1;
      r.value = '0;
      case (func)
         FN_TICK: begin
            if (run_mode == RS_RUNNING) begin
               seg_cnt = add_clip(seg_cnt, CNT_W'(1));
            end
         end
         FN_START: begin
            if (run_mode == RS_IDLE) begin
               total_cnt = '0;
               open_entry();
               seg_cnt = '0;
               run_mode = RS_RUNNING;
            end else if (run_mode == RS_STOPPED) begin
               seg_cnt = '0;
               run_mode = RS_RUNNING;
            end else begin
               r.ok = 1'b0;
            end
         end
         FN_STOP: begin
            if (run_mode == RS_RUNNING) begin
               fold_segment();
               seg_cnt = '0;
               run_mode = RS_STOPPED;
            end else begin
               r.ok = 1'b0;
            end
         end
         FN_LAP: begin
            if (run_mode == RS_RUNNING) begin
               r.value = seg_cnt;
               fold_segment();
               open_entry();
               seg_cnt = '0;
            end else begin
               r.ok = 1'b0;
            end
         end
         FN_CLEAR: begin
            total_cnt = '0;
            seg_cnt = '0;
            lap_count = '0;
            run_mode = RS_IDLE;
         end
         FN_READ_TOTAL: begin
            if (run_mode == RS_RUNNING) begin
               r.value = add_clip(total_cnt, seg_cnt);
            end else if (run_mode == RS_STOPPED) begin
               r.value = total_cnt;
            end
         end
         FN_READ_LOG: begin
            // the newest entry leaves out the running segment
            if (LIM_W'(idx) < lap_count) begin
               slot = head_slot - idx;
               r.value = lap_log[slot];
            end else begin
               r.ok = 1'b0;
            end
         end
         default: begin
            r.value = CNT_W'(run_mode);
         end
      endcase
      return r;
   endfunction

   task automatic issue(input logic [2:0] func, input logic [3:0] idx,
                        input logic typed, input sw_resp_type written);
      sw_resp_type predicted;
      start <= 1'b1;
      req_func <= func;
      req_log_index <= idx;
      do @(posedge clock); while (!(start && !busy));
      predicted = apply_command(func, idx);
      pending_resps.push_back(typed ? written : predicted);
   endtask

   task automatic hold_off(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) begin
         return;
      end
      if (r < 90) begin
         hold_off($urandom_range(1, 3));
      end else if (r < 97) begin
         hold_off($urandom_range(4, 12));
      end else begin
         hold_off($urandom_range(20, 60));
      end
   endtask

   // hold commands until every response is in and the log write-back is done
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_resps.size() != 0);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   task automatic write_ring_size(input logic [LIM_W-1:0] size);
      drain();
      csr_valid <= 1'b1;
      csr_max_log_num <= size;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      ring_cfg = size;
      csr_valid <= 1'b0;
   endtask

   // bias toward running sequences so laps and ring wrap happen often
   task automatic random_command();
      int         r;
      logic [2:0] func;
      logic [3:0] idx;
      r = $urandom_range(0, 99);
      if (r < 38) begin
         func = FN_TICK;
         if (run_mode != RS_RUNNING && $urandom_range(0, 9) < 7) begin
            func = FN_START;
         end
      end else if (r < 46) begin
         func = FN_START;
      end else if (r < 52) begin
         func = FN_STOP;
      end else if (r < 64) begin
         func = FN_LAP;
      end else if (r < 67) begin
         func = FN_CLEAR;
      end else if (r < 75) begin
         func = FN_READ_TOTAL;
      end else if (r < 92) begin
         func = FN_READ_LOG;
      end else begin
         func = FN_READ_STATE;
      end
      if ($urandom_range(0, 1) == 0 || lap_count == '0) begin
         idx = 4'($urandom_range(0, 15));
      end else begin
         idx = 4'($urandom_range(0, lap_count - 1));
      end
      random_gap();
      issue(func, idx, 1'b0, '0);
   endtask

   always @(posedge clock) begin : resp_check
      sw_resp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_resps.size() == 0) begin
            $display("%0t: unexpected response ok=%0b value=%08h", $time, rsp_ok, rsp_value);
            mismatches++;
         end else begin
            want = pending_resps.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
               mismatches++;
            end
            if (rsp_value !== want.value) begin
               $display("%0t: value expected %08h actual %08h", $time, want.value,
                        rsp_value);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  pending_resps.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [LIM_W-1:0] ring_sizes [NUM_PHASES];
      int               n;
      int               phase;
      reset = 1'b1;
      start = 1'b0;
      req_func = FN_TICK;
      req_log_index = '0;
      csr_valid = 1'b0;
      csr_max_log_num = LIM_W'(LOG_DEPTH);
      ring_cfg = LIM_W'(LOG_DEPTH);
      run_mode = RS_IDLE;
      total_cnt = '0;
      seg_cnt = '0;
      head_slot = '0;
      lap_count = '0;
      for (n = 0; n < LOG_DEPTH; n++) begin
         lap_log[n] = '0;
      end
      // full ring first, then shrink without clearing so surplus entries linger
      ring_sizes = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17,
                     LIM_W'($urandom_range(1, LOG_DEPTH))};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < NUM_DIRECTED; n++) begin
         random_gap();
         issue(dir_rows[n].func, dir_rows[n].idx, dir_rows[n].typed,
               '{ok: dir_rows[n].ok, value: dir_rows[n].value});
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_ring_size(ring_sizes[phase]);
         no_gaps = (phase == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               drain();
            end
            random_command();
         end
      end

      drain();
      repeat (SETTLE_TIME) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
